@@ rtl/stsrch_pkg.sv @@
// Shared types and constants of the scope edge trigger search block.
`default_nettype none

package stsrch_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 17;
  localparam int WINDOW_W  = 12;
  localparam int IDX_W     = 11;
  localparam int OFFSET_W  = 16;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam int LEN_REG_W  = 12;
  localparam int MODE_W     = 2;
  localparam int HYST_W     = 15;

  localparam logic [LEN_REG_W-1:0] LEN_RESET  = 12'd2048;
  localparam logic [MODE_W-1:0]    MODE_RESET = 2'd2;
  localparam logic [HYST_W-1:0]    HYST_RESET = 15'd2621;

  localparam logic [1:0] REG_ACTIVE_LENGTH    = 2'd0;
  localparam logic [1:0] REG_TRIGGER_MODE     = 2'd1;
  localparam logic [1:0] REG_HYSTERESIS_LEVEL = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FREE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HYST = 2'd2;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam int DIV_W     = 18;
  localparam int DIVD_W    = 16;
  localparam int QUOT_W    = 16;
  localparam int CNT_W     = 5;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd16;

  localparam int MIN_DIFF_SUM = 7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED_POS,
    ST_RED_LB,
    ST_PRIME,
    ST_LOAD,
    ST_WALK,
    ST_FRAC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [DIVD_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/stsrch_if.sv @@
// Request and result channel interfaces of the scope edge trigger search block.
`default_nettype none

interface stsrch_item_if import stsrch_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [WINDOW_W-1:0]        window_samples;

  modport source (
    output valid, opcode, left_sample, right_sample, window_samples,
    input  ready
  );
  modport sink (
    input  valid, opcode, left_sample, right_sample, window_samples,
    output ready
  );
endinterface

interface stsrch_result_if import stsrch_pkg::*;;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    trigger_index;
  logic [OFFSET_W-1:0] trigger_offset;
  logic                locked;

  modport source (
    output valid, trigger_index, trigger_offset, locked,
    input  ready
  );
  modport sink (
    input  valid, trigger_index, trigger_offset, locked,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/stsrch_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module stsrch_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/stsrch_div.sv @@
// Sequential restoring divider, one quotient bit per cycle, for remainders and fractions.
`default_nettype none

module stsrch_div import stsrch_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvsr;
  logic [DIVD_W-1:0] dvd;
  logic [QUOT_W-1:0] quot;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    reduced;
  logic              ge;

  assign shifted = {rem, dvd[DIVD_W-1]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign reduced = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      dvd  <= req.dividend;
      dvsr <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? reduced[DIV_W-1:0] : shifted[DIV_W-1:0];
      quot <= {quot[QUOT_W-2:0], ge};
      dvd  <= dvd << 1;
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;
  assign rsp.quot = quot;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rem < dvsr))
    else $error("partial remainder reached the divisor");

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while still working");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("divider finished without a preceding run");

endmodule

`default_nettype wire

@@ rtl/scope_edge_trigger_search.sv @@
// Top level of the scope edge trigger search: sample ring, control sequencer and register port.
//
// A request on the item channel either stores one stereo sample pair (opcode 0) or searches
// the ring for the latest rising zero crossing, through the hysteresis band in that mode
// (opcode 1); free run does not search. Stores give no result; a search gives exactly one
// result on the result channel: start index, Q0.16 fraction and lock flag. Stores stream
// at one per cycle while the block is idle. The backward walk of a search reads the ring
// memory one entry per cycle on its single read port and covers at most active_length/2
// entries. A hysteresis lock with a sum difference of at least 7 runs the shared bit-serial
// divider for its fraction before the result is loaded. Free run skips the walk.
// The result sits in an output register; stores are taken while it waits, and a further
// search finishes only once that register is free, so a stalled receiver holds back
// searches, and stores as well once a further search waits to finish.
// After reset the ring is cleared, one entry per cycle through every address, and then the
// write position and lookback are reduced modulo the length in the shared divider; no request
// is taken meanwhile. The same reduction follows every write of active_length.
// Registers lie at byte addresses 0, 4 and 8 of the APB port; pready is always high.
`default_nettype none

module scope_edge_trigger_search import stsrch_pkg::*; #(
  parameter int RING_DEPTH = 2048,
  parameter int LOOKBACK   = 64
) (
  input  logic               clk,
  input  logic               rst,
  stsrch_item_if.sink        item,
  stsrch_result_if.source    result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(RING_DEPTH + 1);
  localparam logic [LW-1:0] LEN_MAX = LW'(RING_DEPTH);

  state_t state;
  state_t state_next;

  logic [LEN_REG_W-1:0] active_length;
  logic [MODE_W-1:0]    trigger_mode;
  logic [HYST_W-1:0]    hysteresis_level;

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wp;
  logic [AW-1:0] pos;
  logic [AW-1:0] lbm;
  logic          dirty;

  logic [AW-1:0]                s_idx;
  logic [LW-1:0]                s_cnt;
  logic signed [SUM_W-1:0]      v_next;
  logic [AW-1:0]                res_index;
  logic [OFFSET_W-1:0]          res_offset;
  logic                         res_locked;

  logic                out_valid;
  logic [AW-1:0]       out_index;
  logic [OFFSET_W-1:0] out_offset;
  logic                out_locked;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] mem_rdata;

  logic                    item_ready;
  logic                    item_acc;
  logic                    store_acc;
  logic                    search_acc;
  logic                    cfg_wr;
  logic                    len_wr;
  logic                    out_load;
  logic                    walk_mode;
  logic [LW-1:0]           len;
  logic [LW-1:0]           depth;
  logic [LW-1:0]           win_clamped;
  logic [LW-1:0]           pos_plus1;
  logic [AW-1:0]           pos_inc;
  logic [AW-1:0]           dec_idx;
  logic [LW:0]             free_sum;
  logic [AW-1:0]           free_idx;
  logic [LW:0]             start_sum;
  logic [AW-1:0]           start_idx;
  logic signed [SUM_W-1:0] store_sum;
  logic signed [SUM_W-1:0] v_cur;
  logic signed [DIV_W-1:0] band;
  logic signed [DIV_W-1:0] vc_ext;
  logic signed [DIV_W-1:0] vn_ext;
  logic signed [DIV_W-1:0] diff;
  logic signed [DIV_W-1:0] neg_cur;
  logic                    hyst_hit;
  logic                    zero_hit;
  logic                    hit;
  logic [AW+IDX_W-1:0]     idx_wide;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign len_wr = cfg_wr && (paddr[3:2] == REG_ACTIVE_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length    <= LEN_RESET;
      trigger_mode     <= MODE_RESET;
      hysteresis_level <= HYST_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ACTIVE_LENGTH:    active_length    <= pwdata[LEN_REG_W-1:0];
        REG_TRIGGER_MODE:     trigger_mode     <= pwdata[MODE_W-1:0];
        REG_HYSTERESIS_LEVEL: hysteresis_level <= pwdata[HYST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE_LENGTH:    prdata = PDATA_W'(active_length);
      REG_TRIGGER_MODE:     prdata = PDATA_W'(trigger_mode);
      REG_HYSTERESIS_LEVEL: prdata = PDATA_W'(hysteresis_level);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    if (active_length == '0) begin
      len = LW'(1);
    end else if (32'(active_length) > 32'(RING_DEPTH)) begin
      len = LEN_MAX;
    end else begin
      len = LW'(active_length);
    end
  end

  assign depth     = len >> 1;
  assign walk_mode = (trigger_mode == MODE_ZERO) || (trigger_mode == MODE_HYST);

  assign item_acc   = item.valid && item_ready;
  assign store_acc  = item_acc && (item.opcode == OP_STORE);
  assign search_acc = item_acc && (item.opcode == OP_SEARCH);
  assign item.ready = item_ready;

  assign store_sum = SUM_W'(item.left_sample) + SUM_W'(item.right_sample);
  assign pos_plus1 = LW'(pos) + LW'(1);
  assign pos_inc   = (pos_plus1 == len) ? '0 : AW'(pos_plus1);
  assign dec_idx   = (s_idx == '0) ? AW'(len - LW'(1)) : s_idx - AW'(1);

  assign win_clamped = (32'(item.window_samples) > 32'(len)) ? len : LW'(item.window_samples);
  assign free_sum    = (LW+1)'(pos) + (LW+1)'(len) - (LW+1)'(win_clamped);
  assign free_idx    = (free_sum >= (LW+1)'(len)) ? AW'(free_sum - (LW+1)'(len)) : AW'(free_sum);
  assign start_sum   = (LW+1)'(pos) + (LW+1)'(len) - (LW+1)'(lbm);
  assign start_idx   = (start_sum >= (LW+1)'(len)) ? AW'(start_sum - (LW+1)'(len))
                                                   : AW'(start_sum);

  assign v_cur    = mem_rdata;
  assign vc_ext   = DIV_W'(v_cur);
  assign vn_ext   = DIV_W'(v_next);
  assign band     = {2'b00, hysteresis_level, 1'b0};
  assign diff     = vn_ext - vc_ext;
  assign neg_cur  = -vc_ext;
  assign hyst_hit = (vc_ext < -band) && (vn_ext > band);
  assign zero_hit = (v_cur <= 0) && (v_next > 0);
  assign hit      = (trigger_mode == MODE_HYST) ? hyst_hit : zero_hit;

  assign out_load = (state == ST_DONE) && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    div_req    = '0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(RING_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (dirty) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(wp);
          div_req.divisor  = DIV_W'(len);
          state_next       = ST_RED_POS;
        end else begin
          item_ready = 1'b1;
          if (search_acc) begin
            state_next = (walk_mode && (depth != '0)) ? ST_PRIME : ST_DONE;
          end
        end
      end
      ST_RED_POS: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIVD_W'(LOOKBACK);
          div_req.divisor  = DIV_W'(len);
          state_next       = ST_RED_LB;
        end
      end
      ST_RED_LB: begin
        if (div_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_PRIME: state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_WALK;
      ST_WALK: begin
        if (hit) begin
          if ((trigger_mode == MODE_HYST) && (diff >= DIV_W'(MIN_DIFF_SUM))) begin
            div_req.start    = 1'b1;
            div_req.rem_init = neg_cur;
            div_req.divisor  = diff;
            state_next       = ST_FRAC;
          end else begin
            state_next = ST_DONE;
          end
        end else if (s_cnt == LW'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_FRAC: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      dirty     <= 1'b1;
      wp        <= '0;
      pos       <= '0;
      lbm       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (len_wr) begin
        dirty <= 1'b1;
      end else if ((state == ST_IDLE) && dirty) begin
        dirty <= 1'b0;
      end
      if (store_acc) begin
        wp  <= pos_inc;
        pos <= pos_inc;
      end
      if ((state == ST_RED_POS) && div_rsp.done) begin
        pos <= AW'(div_rsp.rem);
      end
      if ((state == ST_RED_LB) && div_rsp.done) begin
        lbm <= AW'(div_rsp.rem);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (search_acc) begin
      res_index  <= free_idx;
      res_offset <= '0;
      res_locked <= 1'b0;
      s_idx      <= start_idx;
      s_cnt      <= depth;
    end
    if (state == ST_LOAD) begin
      v_next <= mem_rdata;
      s_idx  <= dec_idx;
    end
    if (state == ST_WALK) begin
      if (hit) begin
        res_index  <= s_idx;
        res_locked <= 1'b1;
      end else begin
        v_next <= mem_rdata;
        s_idx  <= dec_idx;
        s_cnt  <= s_cnt - LW'(1);
      end
    end
    if ((state == ST_FRAC) && div_rsp.done) begin
      res_offset <= div_rsp.quot;
    end
    if (out_load) begin
      out_index  <= res_index;
      out_offset <= res_offset;
      out_locked <= res_locked;
    end
  end

  assign mem_we    = (state == ST_CLEAR) || store_acc;
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : pos;
  assign mem_wdata = (state == ST_CLEAR) ? '0 : store_sum;
  assign mem_raddr = (state == ST_PRIME) ? s_idx : dec_idx;

  stsrch_ram #(
    .WIDTH (SUM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stsrch_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign idx_wide              = {IDX_W'(0), out_index};
  assign result.valid          = out_valid;
  assign result.trigger_index  = idx_wide[IDX_W-1:0];
  assign result.trigger_offset = out_offset;
  assign result.locked         = out_locked;

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !dirty) |-> (LW'(pos) < len))
    else $error("write position not below the active length");

  a_lookback_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE) && !dirty) |-> (LW'(lbm) < len))
    else $error("lookback not below the active length");

  a_no_write_during_search: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == ST_CLEAR) || (state == ST_IDLE)))
    else $error("ring written while a search walks it");

  a_offset_needs_lock: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_offset != '0)) |-> out_locked)
    else $error("fraction given without a lock");

endmodule

`default_nettype wire

@@ bench/scope_edge_trigger_search_test.sv @@
// Self-checking testbench of the scope edge trigger search block.
`timescale 1ns / 1ps

module scope_edge_trigger_search_test;
  import stsrch_pkg::*;

  localparam int RING_DEPTH = 2048;
  localparam int LOOKBACK = 64;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_REQUESTS = 165;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic                opcode;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [WINDOW_W-1:0] window;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic                locked;
  } trigger_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_FIXED, ROW_SETUP} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 opcode;
    logic [SAMPLE_W-1:0]  left;
    logic [SAMPLE_W-1:0]  right;
    logic [WINDOW_W-1:0]  window;
    logic [LEN_REG_W-1:0] length;
    logic [MODE_W-1:0]    mode;
    logic [HYST_W-1:0]    hyst;
    logic [IDX_W-1:0]     index;
    logic [OFFSET_W-1:0]  offset;
    logic                 locked;
  } row_t;

  // Fixed rows carry their expected trigger; setup rows rewrite all three registers.
  row_t directed_plan [25] = '{
    '{ROW_FIXED, OP_SEARCH, 16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_FIXED, OP_SEARCH, 16'h0000, 16'h0000, 12'hFFF, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'h8000, 16'h8000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'h7FFF, 16'h7FFF, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'h8000, 16'h7FFF, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'h7FFF, 16'h8000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'd2048, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'd64, MODE_HYST, 15'd0, 11'd0, 16'd0,
      1'b0},
    '{ROW_FIXED, OP_SEARCH, 16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd32768,
      1'b1},
    '{ROW_ITEM, OP_STORE, 16'hFFFF, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'h0001, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_FIXED, OP_SEARCH, 16'h0000, 16'h0000, 12'd100, 12'd0, 2'd0, 15'd0, 11'd4, 16'd0, 1'b1},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'd64, MODE_ZERO, 15'd0, 11'd0, 16'd0,
      1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'd5, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'd64, MODE_SPARE, 15'd0, 11'd0, 16'd0,
      1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'd64, MODE_FREE, 15'd32767, 11'd0,
      16'd0, 1'b0},
    '{ROW_FIXED, OP_SEARCH, 16'h0000, 16'h0000, 12'd64, 12'd0, 2'd0, 15'd0, 11'd6, 16'd0, 1'b0},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'hFFF, MODE_HYST, 15'd32767, 11'd0,
      16'd0, 1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'hFFF, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_SETUP, OP_STORE, 16'h0000, 16'h0000, 12'd0, 12'd0, MODE_ZERO, 15'd2621, 11'd0, 16'd0,
      1'b0},
    '{ROW_ITEM, OP_STORE, 16'h0005, 16'h0005, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'd1, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_STORE, 16'hFFFB, 16'hFFFB, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0},
    '{ROW_ITEM, OP_SEARCH, 16'h0000, 16'h0000, 12'd0, 12'd0, 2'd0, 15'd0, 11'd0, 16'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  stsrch_item_if item_ch ();
  stsrch_result_if result_ch ();

  logic signed [SUM_W-1:0] sum_ring [RING_DEPTH];
  int unsigned write_pos;
  logic [LEN_REG_W-1:0] cfg_length;
  logic [MODE_W-1:0] cfg_mode;
  logic [HYST_W-1:0] cfg_hyst;

  trigger_t expected_triggers [$];
  int unsigned mismatches = 0;
  int unsigned triggers_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  scope_edge_trigger_search #(
    .RING_DEPTH(RING_DEPTH),
    .LOOKBACK(LOOKBACK)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic bit model_request(input request_t req, output trigger_t outcome);
    int unsigned len;
    int unsigned pos;
    int unsigned win;
    int unsigned i;
    int unsigned i_cur;
    int unsigned c;
    int band;
    int v_next;
    int v_cur;
    int diff;
    bit found;
    len = cfg_length;
    if (len < 1) len = 1;
    if (len > RING_DEPTH) len = RING_DEPTH;
    pos = write_pos % len;
    outcome = '0;
    if (req.opcode == OP_STORE) begin
      sum_ring[pos] = int'($signed(req.left)) + int'($signed(req.right));
      write_pos = (pos + 1 == len) ? 0 : pos + 1;
      return 1'b0;
    end
    win = req.window;
    if (win > len) win = len;
    outcome.index = IDX_W'((pos + len - win) % len);
    if (cfg_mode != MODE_FREE) begin
      band = 2 * int'(cfg_hyst);
      i = (pos + len - LOOKBACK % len) % len;
      v_next = sum_ring[i];
      found = 1'b0;
      for (c = 0; c < len / 2 && !found; c++) begin
        i_cur = (i + len - 1) % len;
        v_cur = sum_ring[i_cur];
        if (cfg_mode == MODE_HYST && v_cur < -band && v_next > band) begin
          diff = v_next - v_cur;
          if (diff >= MIN_DIFF_SUM) outcome.offset = OFFSET_W'((longint'(-v_cur) << 16) / diff);
          found = 1'b1;
        end else if (cfg_mode == MODE_ZERO && v_cur <= 0 && v_next > 0) begin
          found = 1'b1;
        end
        if (found) outcome.index = IDX_W'(i_cur);
        v_next = v_cur;
        i = i_cur;
      end
      outcome.locked = found;
    end
    return 1'b1;
  endfunction

  function automatic logic [SAMPLE_W-1:0] clip16(input int level);
    if (level > 32767) return 16'h7FFF;
    if (level < -32768) return 16'h8000;
    return SAMPLE_W'(level);
  endfunction

  task automatic send_request(input request_t req, input bit fixed, input trigger_t fixed_result);
    trigger_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= req.opcode;
    item_ch.left_sample <= req.left;
    item_ch.right_sample <= req.right;
    item_ch.window_samples <= req.window;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (model_request(req, predicted)) expected_triggers.push_back(fixed ? fixed_result : predicted);
  endtask

  task automatic drain(input int unsigned extra);
    item_ch.valid <= 1'b0;
    while (expected_triggers.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_LENGTH: cfg_length = value[LEN_REG_W-1:0];
      REG_TRIGGER_MODE: cfg_mode = value[MODE_W-1:0];
      REG_HYSTERESIS_LEVEL: cfg_hyst = value[HYST_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [LEN_REG_W-1:0] len, input logic [MODE_W-1:0] mode,
                               input logic [HYST_W-1:0] hyst);
    drain(16);
    write_register(REG_ACTIVE_LENGTH, PDATA_W'(len));
    write_register(REG_TRIGGER_MODE, PDATA_W'(mode));
    write_register(REG_HYSTERESIS_LEVEL, PDATA_W'(hyst));
  endtask

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      triggers_seen++;
      if (expected_triggers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d with nothing pending: index %0d offset %0d locked %0d",
                   triggers_seen, result_ch.trigger_index, result_ch.trigger_offset,
                   result_ch.locked);
        end
      end else begin
        if (result_ch.trigger_index !== expected_triggers[0].index ||
            result_ch.trigger_offset !== expected_triggers[0].offset ||
            result_ch.locked !== expected_triggers[0].locked) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected index %0d offset %0d locked %0d", triggers_seen,
                     expected_triggers[0].index, expected_triggers[0].offset,
                     expected_triggers[0].locked);
            $display("result %0d: actual   index %0d offset %0d locked %0d", triggers_seen,
                     result_ch.trigger_index, result_ch.trigger_offset, result_ch.locked);
          end
        end
        void'(expected_triggers.pop_front());
      end
    end
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("scope_edge_trigger_search: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    request_t req;
    trigger_t fixed_result;
    row_t row;
    int unsigned phase_length;
    logic [MODE_W-1:0] phase_mode;
    logic [HYST_W-1:0] phase_hyst;
    int unsigned sent;
    int unsigned burst;
    int wave_kind;
    int wave_period;
    int wave_amp;
    int wave_noise;
    int wave_step;
    int k;
    int level;

    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_STORE;
    item_ch.left_sample = '0;
    item_ch.right_sample = '0;
    item_ch.window_samples = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    foreach (sum_ring[n]) sum_ring[n] = '0;
    write_pos = 0;
    cfg_length = LEN_RESET;
    cfg_mode = MODE_RESET;
    cfg_hyst = HYST_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      row = directed_plan[r];
      if (row.kind == ROW_SETUP) begin
        apply_setting(row.length, row.mode, row.hyst);
      end else begin
        req = '{row.opcode, row.left, row.right, row.window};
        fixed_result = '{row.index, row.offset, row.locked};
        send_request(req, row.kind == ROW_FIXED, fixed_result);
      end
    end

    wave_kind = 0;
    wave_period = 40;
    wave_amp = 20000;
    wave_noise = 100;
    wave_step = 0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 2 || p == 9) phase_length = RING_DEPTH;
      else if (p == 6) phase_length = 128;
      else phase_length = $urandom_range(128, 320);
      case (p % 6)
        0, 2: phase_mode = MODE_HYST;
        1, 3: phase_mode = MODE_ZERO;
        4: phase_mode = MODE_FREE;
        default: phase_mode = MODE_SPARE;
      endcase
      case (p % 4)
        0: phase_hyst = $urandom_range(600);
        1: phase_hyst = 0;
        2: phase_hyst = $urandom_range(32767);
        default: phase_hyst = $urandom_range(1000, 8000);
      endcase
      if (p == PHASE_COUNT - 1) phase_hyst = 15'd32767;
      apply_setting(LEN_REG_W'(phase_length), phase_mode, phase_hyst);
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 86;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 86;
        end
        default: begin
          sender_idle_pct = 34;
          receiver_stall_pct = 34;
        end
      endcase

      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        if ($urandom_range(99) < 85) begin
          if ($urandom_range(9) == 0) begin
            wave_kind = $urandom_range(2);
            wave_period = $urandom_range(8, 120);
            wave_amp = $urandom_range(32767);
            wave_noise = $urandom_range(3) == 0 ? $urandom_range(4000) : $urandom_range(200);
          end
          burst = $urandom_range(4, 40);
          repeat (burst) begin
            k = wave_step % wave_period;
            wave_step++;
            case (wave_kind)
              0: level = (2 * k < wave_period) ? -wave_amp + (4 * wave_amp * k) / wave_period
                                               : 3 * wave_amp - (4 * wave_amp * k) / wave_period;
              1: level = (2 * k < wave_period) ? -wave_amp : wave_amp;
              default: level = -wave_amp + (2 * wave_amp * k) / wave_period;
            endcase
            req.opcode = OP_STORE;
            req.left = clip16(level + int'($urandom_range(2 * wave_noise)) - wave_noise);
            req.right = clip16(level + int'($urandom_range(2 * wave_noise)) - wave_noise);
            req.window = '0;
            send_request(req, 1'b0, '0);
            sent++;
          end
          req.opcode = OP_SEARCH;
          req.left = SAMPLE_W'($urandom);
          req.right = SAMPLE_W'($urandom);
          req.window = $urandom_range(3) == 0 ? WINDOW_W'($urandom_range(4095))
                                              : WINDOW_W'($urandom_range(phase_length));
          send_request(req, 1'b0, '0);
          sent++;
        end else begin
          req.opcode = $urandom_range(1) == 1 ? OP_SEARCH : OP_STORE;
          req.left = SAMPLE_W'($urandom);
          req.right = SAMPLE_W'($urandom);
          req.window = WINDOW_W'($urandom);
          send_request(req, 1'b0, '0);
          sent++;
        end
      end
    end

    drain(64);
    if (mismatches == 0 && expected_triggers.size() == 0) begin
      $display("scope_edge_trigger_search: match");
    end else begin
      $display("scope_edge_trigger_search: mismatch");
    end
    $finish;
  end

endmodule
